// ===== rtl/rtpx_pkg.sv =====
// rtpx_pkg: shared types and constants for the rtp header extractor
// no dependencies; used by every rtl file of the block but rtpx_if, by scoped names
package rtpx_pkg;

  // byte counter saturates at the largest packet size
  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned OFS_W            = $clog2(MAX_PACKET_BYTES + 1);
  typedef logic [OFS_W-1:0] ofs_t;

  localparam ofs_t OFS_MAX = ofs_t'(MAX_PACKET_BYTES);

  // byte positions inside the packet (fixed 20 byte ip header)
  localparam ofs_t OFS_PROTO     = ofs_t'(9);
  localparam ofs_t OFS_SRC_ADDR0 = ofs_t'(12);
  localparam ofs_t OFS_SRC_ADDR3 = ofs_t'(15);
  localparam ofs_t OFS_DST_ADDR0 = ofs_t'(16);
  localparam ofs_t OFS_DST_ADDR3 = ofs_t'(19);
  localparam ofs_t OFS_SPORT0    = ofs_t'(20);
  localparam ofs_t OFS_SPORT1    = ofs_t'(21);
  localparam ofs_t OFS_DPORT0    = ofs_t'(22);
  localparam ofs_t OFS_DPORT1    = ofs_t'(23);
  localparam ofs_t OFS_UDP_LEN0  = ofs_t'(24);
  localparam ofs_t OFS_UDP_LEN1  = ofs_t'(25);
  localparam ofs_t OFS_RTP_FLG0  = ofs_t'(28);
  localparam ofs_t OFS_RTP_FLG1  = ofs_t'(29);
  localparam ofs_t OFS_RTP_SEQ0  = ofs_t'(30);
  localparam ofs_t OFS_RTP_SEQ1  = ofs_t'(31);
  localparam ofs_t OFS_RTP_TS0   = ofs_t'(32);
  localparam ofs_t OFS_RTP_TS3   = ofs_t'(35);

  // filter constants
  localparam logic [15:0] MIN_RECORD_BYTES = 16'd40;
  localparam logic [15:0] HEADER_OVERHEAD  = 16'd20;
  localparam logic [1:0]  RTP_VERSION      = 2'd2;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROTOCOL_MATCH   = 2'd0,
    CFG_PAYLOAD_TYPE_MIN = 2'd1,
    CFG_PAYLOAD_TYPE_MAX = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] PROTOCOL_MATCH_RST   = 8'd17;
  localparam logic [6:0] PAYLOAD_TYPE_MIN_RST = 7'd96;
  localparam logic [6:0] PAYLOAD_TYPE_MAX_RST = 7'd127;

  // one captured packet summary, handed from front to back
  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [15:0] udp_len;
    logic [15:0] rtp_flags;
    logic [15:0] rtp_seq;
    logic [31:0] rtp_ts;
    logic [31:0] arrival;
    ofs_t        count;
  } pkt_rec_t;

  // summary queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

// ===== rtl/rtpx_if.sv =====
// rtpx_if: valid/ready channel interfaces for packet bytes and records
// depends on nothing; each interface carries the beat payload as named fields
interface rtpx_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] now_ms;

  modport source (output valid, data_byte, last_byte, now_ms, input ready);
  modport sink   (input valid, data_byte, last_byte, now_ms, output ready);
endinterface

interface rtpx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rtp_timestamp;
  logic [15:0] rtp_sequence;
  logic        marker_bit;
  logic [6:0]  payload_kind;
  logic [15:0] payload_bytes;
  logic [31:0] source_address;
  logic [15:0] source_port;
  logic [31:0] dest_address;
  logic [15:0] dest_port;
  logic [31:0] arrival_ms;
  logic [15:0] packet_length;

  modport source (output valid, rtp_timestamp, rtp_sequence, marker_bit, payload_kind,
                  payload_bytes, source_address, source_port, dest_address, dest_port,
                  arrival_ms, packet_length, input ready);
  modport sink   (input valid, rtp_timestamp, rtp_sequence, marker_bit, payload_kind,
                  payload_bytes, source_address, source_port, dest_address, dest_port,
                  arrival_ms, packet_length, output ready);
endinterface

// ===== rtl/rtp_header_extractor.sv =====
// rtp_header_extractor: ipv4/udp/rtp header capture and record filter
// throughput: one byte beat per cycle, in_ready drops only while the 4-entry summary queue is full
// record path: the summary is written into the queue with the packet's last byte, then moved from the
// queue head into the output register when that is free; the back end drains one queued summary
// per cycle while records are taken, so back-to-back short packets do not stall
// reset: synchronous active-low rst_n clears capture state, the queue and the output register,
// and loads protocol 17 and payload type range 96..127
module rtp_header_extractor (
  input  logic                            clk,
  input  logic                            rst_n,
  rtpx_in_if.sink                         in_bus,
  rtpx_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [rtpx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpx_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic               push_valid;
  logic               push_ready;
  rtpx_pkg::pkt_rec_t push_rec;
  logic               pop_valid;
  logic               pop_en;
  rtpx_pkg::pkt_rec_t pop_rec;

  // byte capture front end
  rtpx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready)
  );

  // summary queue
  rtpx_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push_valid),
    .wr_rec   (push_rec),
    .wr_ready (push_ready),
    .rd_en    (pop_en),
    .rd_rec   (pop_rec),
    .rd_valid (pop_valid)
  );

  // filter and record output
  rtpx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_rec   (pop_rec),
    .pop_en    (pop_en),
    .out_bus   (out_bus)
  );

endmodule

// ===== rtl/rtpx_front.sv =====
// rtpx_front: takes packet bytes, captures header fields by byte offset
// depends on rtpx_pkg and rtpx_in_if; pushes one summary per packet at its last byte
module rtpx_front (
  input  logic                clk,
  input  logic                rst_n,
  rtpx_in_if.sink             in_bus,
  output logic                push_valid,
  output rtpx_pkg::pkt_rec_t  push_rec,
  input  logic                push_ready
);

  rtpx_pkg::ofs_t     offset_r;
  rtpx_pkg::ofs_t     offset_nxt;
  rtpx_pkg::pkt_rec_t cap_r;
  rtpx_pkg::pkt_rec_t cap_nxt;
  logic               accept;

  // one beat a cycle while the queue has room
  assign in_bus.ready = push_ready;
  assign accept       = in_bus.valid && push_ready;

  // saturating byte count, also the packet length at the last byte
  assign offset_nxt = (offset_r == rtpx_pkg::OFS_MAX) ? offset_r
                                                      : offset_r + rtpx_pkg::ofs_t'(1);

  // offset-keyed capture of the current beat
  always_comb begin
    cap_nxt = cap_r;
    if (offset_r == rtpx_pkg::OFS_PROTO) begin
      cap_nxt.protocol = in_bus.data_byte;
    end else if (offset_r inside {[rtpx_pkg::OFS_SRC_ADDR0:rtpx_pkg::OFS_SRC_ADDR3]}) begin
      cap_nxt.src_addr = {cap_r.src_addr[23:0], in_bus.data_byte};
    end else if (offset_r inside {[rtpx_pkg::OFS_DST_ADDR0:rtpx_pkg::OFS_DST_ADDR3]}) begin
      cap_nxt.dst_addr = {cap_r.dst_addr[23:0], in_bus.data_byte};
    end else if (offset_r inside {rtpx_pkg::OFS_SPORT0, rtpx_pkg::OFS_SPORT1}) begin
      cap_nxt.udp_sport = {cap_r.udp_sport[7:0], in_bus.data_byte};
    end else if (offset_r inside {rtpx_pkg::OFS_DPORT0, rtpx_pkg::OFS_DPORT1}) begin
      cap_nxt.udp_dport = {cap_r.udp_dport[7:0], in_bus.data_byte};
    end else if (offset_r inside {rtpx_pkg::OFS_UDP_LEN0, rtpx_pkg::OFS_UDP_LEN1}) begin
      cap_nxt.udp_len = {cap_r.udp_len[7:0], in_bus.data_byte};
    end else if (offset_r inside {rtpx_pkg::OFS_RTP_FLG0, rtpx_pkg::OFS_RTP_FLG1}) begin
      cap_nxt.rtp_flags = {cap_r.rtp_flags[7:0], in_bus.data_byte};
    end else if (offset_r inside {rtpx_pkg::OFS_RTP_SEQ0, rtpx_pkg::OFS_RTP_SEQ1}) begin
      cap_nxt.rtp_seq = {cap_r.rtp_seq[7:0], in_bus.data_byte};
    end else if (offset_r inside {[rtpx_pkg::OFS_RTP_TS0:rtpx_pkg::OFS_RTP_TS3]}) begin
      cap_nxt.rtp_ts = {cap_r.rtp_ts[23:0], in_bus.data_byte};
    end
    cap_nxt.arrival = in_bus.now_ms;
    cap_nxt.count   = offset_nxt;
  end

  // summary of the finished packet goes to the queue
  assign push_valid = accept && in_bus.last_byte;
  assign push_rec   = cap_nxt;

  // capture state, cleared after every last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      cap_r    <= '0;
    end else if (accept) begin
      if (in_bus.last_byte) begin
        offset_r <= '0;
        cap_r    <= '0;
      end else begin
        offset_r <= offset_nxt;
        cap_r    <= cap_nxt;
      end
    end
  end

endmodule

// ===== rtl/rtpx_fifo.sv =====
// rtpx_fifo: short summary queue between front and back
// depends on rtpx_pkg; depth set by FIFO_DEPTH, show-ahead read
module rtpx_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  rtpx_pkg::pkt_rec_t  wr_rec,
  output logic                wr_ready,
  input  logic                rd_en,
  output rtpx_pkg::pkt_rec_t  rd_rec,
  output logic                rd_valid
);

  rtpx_pkg::pkt_rec_t             mem_r [rtpx_pkg::FIFO_DEPTH];
  logic [rtpx_pkg::FIFO_AW:0]     wr_ptr_r;
  logic [rtpx_pkg::FIFO_AW:0]     rd_ptr_r;
  logic                           full;
  logic                           empty;

  // pointers carry one wrap bit
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[rtpx_pkg::FIFO_AW] != rd_ptr_r[rtpx_pkg::FIFO_AW]) &&
                 (wr_ptr_r[rtpx_pkg::FIFO_AW-1:0] == rd_ptr_r[rtpx_pkg::FIFO_AW-1:0]);

  assign wr_ready = !full;
  assign rd_valid = !empty;
  assign rd_rec   = mem_r[rd_ptr_r[rtpx_pkg::FIFO_AW-1:0]];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wr_ptr_r[rtpx_pkg::FIFO_AW-1:0]] <= wr_rec;
    end
  end

  // pointer update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rtpx_back.sv =====
// rtpx_back: filters queued packet summaries and drives the record channel
// depends on rtpx_pkg and rtpx_out_if; holds the configuration registers
module rtpx_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rtpx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rtpx_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 pop_valid,
  input  rtpx_pkg::pkt_rec_t                   pop_rec,
  output logic                                 pop_en,
  rtpx_out_if.source                           out_bus
);

  logic [7:0]         protocol_match_r;
  logic [6:0]         ptype_min_r;
  logic [6:0]         ptype_max_r;
  logic               out_valid_r;
  rtpx_pkg::pkt_rec_t out_rec_r;
  logic [15:0]        payload_r;
  logic [15:0]        payload_nxt;
  logic [6:0]         ptype;
  logic               pass;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_match_r <= rtpx_pkg::PROTOCOL_MATCH_RST;
      ptype_min_r      <= rtpx_pkg::PAYLOAD_TYPE_MIN_RST;
      ptype_max_r      <= rtpx_pkg::PAYLOAD_TYPE_MAX_RST;
    end else if (cfg_we) begin
      case (rtpx_pkg::cfg_idx_t'(cfg_index))
        rtpx_pkg::CFG_PROTOCOL_MATCH:   protocol_match_r <= cfg_wdata;
        rtpx_pkg::CFG_PAYLOAD_TYPE_MIN: ptype_min_r      <= cfg_wdata[6:0];
        rtpx_pkg::CFG_PAYLOAD_TYPE_MAX: ptype_max_r      <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // record filter on the queue head
  assign ptype = pop_rec.rtp_flags[6:0];
  assign pass  = (16'(pop_rec.count) >= rtpx_pkg::MIN_RECORD_BYTES) &&
                 (pop_rec.protocol == protocol_match_r) &&
                 (pop_rec.rtp_flags[15:14] == rtpx_pkg::RTP_VERSION) &&
                 (ptype >= ptype_min_r) && (ptype <= ptype_max_r);

  // payload size, udp length less the 20 byte header overhead, floored at zero
  assign payload_nxt = (pop_rec.udp_len >= rtpx_pkg::HEADER_OVERHEAD)
                     ? pop_rec.udp_len - rtpx_pkg::HEADER_OVERHEAD : 16'd0;

  // take the head whenever the output register is free or draining
  assign pop_en = pop_valid && (!out_valid_r || out_bus.ready);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_en) begin
      out_valid_r <= pass;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_en && pass) begin
      out_rec_r <= pop_rec;
      payload_r <= payload_nxt;
    end
  end

  // record beat fields
  assign out_bus.valid          = out_valid_r;
  assign out_bus.rtp_timestamp  = out_rec_r.rtp_ts;
  assign out_bus.rtp_sequence   = out_rec_r.rtp_seq;
  assign out_bus.marker_bit     = out_rec_r.rtp_flags[7];
  assign out_bus.payload_kind   = out_rec_r.rtp_flags[6:0];
  assign out_bus.payload_bytes  = payload_r;
  assign out_bus.source_address = out_rec_r.src_addr;
  assign out_bus.source_port    = out_rec_r.udp_sport;
  assign out_bus.dest_address   = out_rec_r.dst_addr;
  assign out_bus.dest_port      = out_rec_r.udp_dport;
  assign out_bus.arrival_ms     = out_rec_r.arrival;
  assign out_bus.packet_length  = 16'(out_rec_r.count);

endmodule

// ===== rtl/rtpx_checker.sv =====
// rtpx_checker: port-level checks on the rtp header extractor
// depends on rtpx_pkg; attached to the top level by the bind at the end of this file
module rtpx_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_packet_length,
  input  logic [15:0] out_payload_bytes,
  input  logic [31:0] out_rtp_timestamp
);

  // record beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rtp_timestamp))
    else $error("record beat changed while stalled");

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("record valid after reset");

  // only packets of full header length produce records
  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_packet_length >= rtpx_pkg::MIN_RECORD_BYTES)
    else $error("record from a short packet");

  // payload size never exceeds the largest udp length less the header overhead
  a_payload_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload_bytes <= 16'hFFFF - rtpx_pkg::HEADER_OVERHEAD)
    else $error("payload size out of range");

endmodule

bind rtp_header_extractor rtpx_checker u_rtpx_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_packet_length (out_bus.packet_length),
  .out_payload_bytes (out_bus.payload_bytes),
  .out_rtp_timestamp (out_bus.rtp_timestamp)
);

// ===== dv/rtp_header_extractor_checker.sv =====
`timescale 1ns / 1ps
// rtp_header_extractor_checker: watches the byte and record channels, predicts each record
// from the captured header bytes and compares it field by field; depends on rtpx_pkg, rtpx_if
module rtp_header_extractor_checker
  import rtpx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rtpx_in_if                    in_mon,
  rtpx_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    records_seen
);

  localparam int unsigned BYTE_CAP     = 65535;
  localparam int unsigned MIN_BYTES    = 40;
  localparam int unsigned UDP_OVERHEAD = 20;
  localparam int unsigned MAX_REPORTS  = 10;

  // first byte position of each captured header field
  localparam int unsigned POS_PROTO     = 9;
  localparam int unsigned POS_SRC_ADDR  = 12;
  localparam int unsigned POS_DST_ADDR  = 16;
  localparam int unsigned POS_SPORT     = 20;
  localparam int unsigned POS_DPORT     = 22;
  localparam int unsigned POS_UDP_LEN   = 24;
  localparam int unsigned POS_RTP_FLAGS = 28;
  localparam int unsigned POS_RTP_SEQ   = 30;
  localparam int unsigned POS_RTP_TS    = 32;

  typedef struct packed {
    logic [31:0] rtp_timestamp;
    logic [15:0] rtp_sequence;
    logic        marker_bit;
    logic [6:0]  payload_kind;
    logic [15:0] payload_bytes;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [31:0] arrival_ms;
    logic [15:0] packet_length;
  } rtp_record_t;

  // register mirror
  logic [7:0]  match_proto;
  logic [6:0]  kind_lo;
  logic [6:0]  kind_hi;

  // header capture of the packet in flight
  int unsigned byte_pos;
  logic [7:0]  proto_cap;
  logic [31:0] src_addr_cap;
  logic [31:0] dst_addr_cap;
  logic [15:0] sport_cap;
  logic [15:0] dport_cap;
  logic [15:0] udp_len_cap;
  logic [15:0] flags_cap;
  logic [15:0] seq_cap;
  logic [31:0] ts_cap;

  rtp_record_t record_q[$];
  int          fails;
  int          checked;

  task automatic clear_capture();
    byte_pos     = 0;
    proto_cap    = '0;
    src_addr_cap = '0;
    dst_addr_cap = '0;
    sport_cap    = '0;
    dport_cap    = '0;
    udp_len_cap  = '0;
    flags_cap    = '0;
    seq_cap      = '0;
    ts_cap       = '0;
  endtask

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got)
      note_failure($sformatf("record %0d %s: expected %0h, got %0h", checked, name, want, got));
  endtask

  // fold one packet byte into the capture and queue a record at a passing last byte
  task automatic take_byte(input logic [7:0] b, input logic last, input logic [31:0] now);
    int unsigned cnt;
    logic [6:0]  kind;
    rtp_record_t rec;
    if (byte_pos == POS_PROTO)
      proto_cap = b;
    else if (byte_pos >= POS_SRC_ADDR && byte_pos < POS_SRC_ADDR + 4)
      src_addr_cap = {src_addr_cap[23:0], b};
    else if (byte_pos >= POS_DST_ADDR && byte_pos < POS_DST_ADDR + 4)
      dst_addr_cap = {dst_addr_cap[23:0], b};
    else if (byte_pos >= POS_SPORT && byte_pos < POS_SPORT + 2)
      sport_cap = {sport_cap[7:0], b};
    else if (byte_pos >= POS_DPORT && byte_pos < POS_DPORT + 2)
      dport_cap = {dport_cap[7:0], b};
    else if (byte_pos >= POS_UDP_LEN && byte_pos < POS_UDP_LEN + 2)
      udp_len_cap = {udp_len_cap[7:0], b};
    else if (byte_pos >= POS_RTP_FLAGS && byte_pos < POS_RTP_FLAGS + 2)
      flags_cap = {flags_cap[7:0], b};
    else if (byte_pos >= POS_RTP_SEQ && byte_pos < POS_RTP_SEQ + 2)
      seq_cap = {seq_cap[7:0], b};
    else if (byte_pos >= POS_RTP_TS && byte_pos < POS_RTP_TS + 4)
      ts_cap = {ts_cap[23:0], b};

    // byte count holds at the cap on very long packets
    cnt = (byte_pos + 1 > BYTE_CAP) ? BYTE_CAP : byte_pos + 1;
    if (byte_pos < BYTE_CAP) byte_pos++;

    if (last) begin
      kind = flags_cap[6:0];
      if (cnt >= MIN_BYTES && proto_cap == match_proto && flags_cap[15:14] == RTP_VERSION &&
          kind >= kind_lo && kind <= kind_hi) begin
        rec.rtp_timestamp  = ts_cap;
        rec.rtp_sequence   = seq_cap;
        rec.marker_bit     = flags_cap[7];
        rec.payload_kind   = kind;
        rec.payload_bytes  = (udp_len_cap >= UDP_OVERHEAD) ? 16'(udp_len_cap - UDP_OVERHEAD) : '0;
        rec.source_address = src_addr_cap;
        rec.source_port    = sport_cap;
        rec.dest_address   = dst_addr_cap;
        rec.dest_port      = dport_cap;
        rec.arrival_ms     = now;
        rec.packet_length  = 16'(cnt);
        record_q.push_back(rec);
      end
      clear_capture();
    end
  endtask

  // predict on each byte beat, compare on each record beat
  always @(posedge clk) begin
    rtp_record_t want;
    if (!rst_n) begin
      match_proto = PROTOCOL_MATCH_RST;
      kind_lo     = PAYLOAD_TYPE_MIN_RST;
      kind_hi     = PAYLOAD_TYPE_MAX_RST;
      clear_capture();
      record_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROTOCOL_MATCH:   match_proto = cfg_wdata;
          CFG_PAYLOAD_TYPE_MIN: kind_lo = cfg_wdata[6:0];
          CFG_PAYLOAD_TYPE_MAX: kind_hi = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        take_byte(in_mon.data_byte, in_mon.last_byte, in_mon.now_ms);
      if (out_mon.valid && out_mon.ready) begin
        if (record_q.size() == 0) begin
          note_failure($sformatf("record with no packet behind it, seq %0h ts %0h",
                                 out_mon.rtp_sequence, out_mon.rtp_timestamp));
        end else begin
          want = record_q.pop_front();
          check_field("rtp_timestamp", want.rtp_timestamp, out_mon.rtp_timestamp);
          check_field("rtp_sequence", 32'(want.rtp_sequence), 32'(out_mon.rtp_sequence));
          check_field("marker_bit", 32'(want.marker_bit), 32'(out_mon.marker_bit));
          check_field("payload_kind", 32'(want.payload_kind), 32'(out_mon.payload_kind));
          check_field("payload_bytes", 32'(want.payload_bytes), 32'(out_mon.payload_bytes));
          check_field("source_address", want.source_address, out_mon.source_address);
          check_field("source_port", 32'(want.source_port), 32'(out_mon.source_port));
          check_field("dest_address", want.dest_address, out_mon.dest_address);
          check_field("dest_port", 32'(want.dest_port), 32'(out_mon.dest_port));
          check_field("arrival_ms", want.arrival_ms, out_mon.arrival_ms);
          check_field("packet_length", 32'(want.packet_length), 32'(out_mon.packet_length));
        end
        checked++;
      end
    end
    fail_count   <= fails;
    pending      <= record_q.size();
    records_seen <= checked;
  end

endmodule

// ===== dv/rtp_header_extractor_tb.sv =====
`timescale 1ns / 1ps
// rtp_header_extractor_tb: packet stimulus, register phases and verdict for the extractor
// depends on rtpx_pkg, rtpx_if, rtp_header_extractor and rtp_header_extractor_checker
module rtp_header_extractor_tb;
  import rtpx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [7:0] UDP_PROTO         = 8'd17;
  localparam int         LONG_HOLD         = 400;
  localparam int         SETTLE_CYCLES     = 24;
  localparam int         RANDOM_BYTES      = 500;
  localparam int         PACKETS_PER_PHASE = 4;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rtpx_in_if  in_if();
  rtpx_out_if out_if();

  int fail_count;
  int pending;
  int records_seen;

  bit src_idle_on;
  bit sink_idle_on;
  int hold_asked;
  int hold_done;

  logic [7:0] pkt_bytes[$];
  logic [7:0] cur_proto;
  logic [6:0] cur_min;
  logic [6:0] cur_max;
  int         packets_sent;
  int         bytes_sent;
  int         settings_used;

  rtp_header_extractor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_if),
    .out_bus  (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  rtp_header_extractor_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .records_seen(records_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // record receiver: random stalls, or one long hold on request
  initial begin
    hold_done    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= !(sink_idle_on && $urandom_range(99) < 11);
      end
    end
  end

  initial begin
    #4ms;
    $display("timeout: %0d records still outstanding", pending);
    $display("rtp_header_extractor_tb: done, errors");
    $finish;
  end

  // one byte beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [7:0] b, input logic last);
    while (src_idle_on && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    in_if.now_ms    <= $urandom;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // build a packet with the given header fields over a filler pattern and send it
  task automatic send_rtp(input int len, input logic [7:0] proto, input logic [1:0] ver,
                          input logic [6:0] kind, input logic [15:0] udp_len, input fill_t fill);
    logic [7:0] v;
    pkt_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: v = 8'h00;
        FILL_ONES: v = 8'hFF;
        default:   v = 8'($urandom);
      endcase
      pkt_bytes.push_back(v);
    end
    if (len > 9) pkt_bytes[9] = proto;
    if (len > 25) begin
      pkt_bytes[24] = udp_len[15:8];
      pkt_bytes[25] = udp_len[7:0];
    end
    if (len > 29) begin
      pkt_bytes[28] = {ver, pkt_bytes[28][5:0]};
      pkt_bytes[29] = {pkt_bytes[29][7], kind};
    end
    for (int i = 0; i < len; i++) send_beat(pkt_bytes[i], i == len - 1);
    packets_sent++;
  endtask

  // write all three registers, optionally poke the unused index too
  task automatic program_regs(input logic [7:0] proto, input logic [7:0] lo,
                              input logic [7:0] hi, input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROTOCOL_MATCH;
    cfg_wdata <= proto;
    @(posedge clk);
    cfg_index <= CFG_PAYLOAD_TYPE_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_PAYLOAD_TYPE_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_IDX_SPARE;
      cfg_wdata <= 8'($urandom);
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_proto = proto;
    cur_min   = lo[6:0];
    cur_max   = hi[6:0];
    settings_used++;
  endtask

  // stop sending, wait for every record, then let queued short packets drain
  task automatic settle_block();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [6:0] kind_in_range();
    if (cur_min <= cur_max) return 7'($urandom_range(cur_max, cur_min));
    return 7'($urandom);
  endfunction

  // mostly ordinary sizes, some short, some longer
  function automatic int pick_len();
    int r;
    r = $urandom_range(9);
    if (r < 7) return $urandom_range(60, 40);
    if (r == 7) return $urandom_range(39, 36);
    if (r == 8) return $urandom_range(200, 61);
    return 40;
  endfunction

  function automatic logic [15:0] pick_udp_len();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'($urandom_range(19, 0));
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom);
    return 16'($urandom_range(1500, 20));
  endfunction

  initial begin
    int         start_bytes;
    int         phase;
    int         pk;
    int         r;
    logic [1:0] ver;
    logic [6:0] kind;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_PROTOCOL_MATCH;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    in_if.now_ms    = '0;
    hold_asked      = 0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    packets_sent    = 0;
    bytes_sent      = 0;
    settings_used   = 1;
    cur_proto       = UDP_PROTO;
    cur_min         = PAYLOAD_TYPE_MIN_RST;
    cur_max         = PAYLOAD_TYPE_MAX_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases under the reset settings
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd96, 16'd20, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd127, 16'hFFFF, FILL_ONES);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd95, 16'd100, FILL_RANDOM);
    send_rtp(39, UDP_PROTO, RTP_VERSION, 7'd100, 16'd100, FILL_RANDOM);
    send_rtp(40, 8'd6, RTP_VERSION, 7'd100, 16'd100, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, 2'd0, 7'd100, 16'd100, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, 2'd1, 7'd100, 16'd100, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, 2'd3, 7'd100, 16'd100, FILL_RANDOM);
    send_rtp(41, UDP_PROTO, RTP_VERSION, 7'd100, 16'd19, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd100, 16'd21, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd100, 16'd0, FILL_ZERO);
    send_rtp(1, UDP_PROTO, RTP_VERSION, 7'd100, 16'd100, FILL_RANDOM);
    send_rtp(64, UDP_PROTO, RTP_VERSION, 7'd110, 16'd44, FILL_RANDOM);

    // all-zero registers
    settle_block();
    program_regs(8'd0, 8'd0, 8'd0, 1'b1);
    send_rtp(40, 8'd0, RTP_VERSION, 7'd0, 16'd60, FILL_RANDOM);
    send_rtp(40, 8'd0, RTP_VERSION, 7'd1, 16'd60, FILL_RANDOM);

    // all-ones writes, type registers keep seven bits
    settle_block();
    program_regs(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_rtp(40, 8'hFF, RTP_VERSION, 7'd127, 16'd60, FILL_ONES);
    send_rtp(40, 8'hFF, RTP_VERSION, 7'd126, 16'd60, FILL_RANDOM);

    // empty payload type range
    settle_block();
    program_regs(UDP_PROTO, 8'd50, 8'd10, 1'b0);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd10, 16'd60, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd30, 16'd60, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd50, 16'd60, FILL_RANDOM);

    // full range, minimum written with its top bit set
    settle_block();
    program_regs(UDP_PROTO, 8'h80, 8'd127, 1'b1);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd0, 16'd60, FILL_RANDOM);
    send_rtp(40, UDP_PROTO, RTP_VERSION, 7'd127, 16'd60, FILL_RANDOM);

    // receiver holds off while minimum-length packets keep coming, queue fills and stalls bytes
    settle_block();
    program_regs(UDP_PROTO, 8'(PAYLOAD_TYPE_MIN_RST), 8'(PAYLOAD_TYPE_MAX_RST), 1'b0);
    src_idle_on = 1'b0;
    hold_asked++;
    repeat (10) send_rtp(40, cur_proto, RTP_VERSION, kind_in_range(), 16'd60, FILL_RANDOM);
    settle_block();
    src_idle_on = 1'b1;

    // random packets over changing register phases
    start_bytes = bytes_sent;
    phase       = 0;
    pk          = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      if (pk % PACKETS_PER_PHASE == 0) begin
        settle_block();
        case ($urandom_range(3))
          0: program_regs(UDP_PROTO, 8'(PAYLOAD_TYPE_MIN_RST), 8'(PAYLOAD_TYPE_MAX_RST), 1'b0);
          1: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
          2: program_regs(8'($urandom), 8'd0, 8'd127, 1'($urandom_range(1)));
          default: program_regs(UDP_PROTO, 8'($urandom_range(60)), 8'($urandom_range(255, 60)),
                                1'b0);
        endcase
        // second random phase runs with no idling on either side
        src_idle_on  = (phase != 1);
        sink_idle_on = (phase != 1);
        phase++;
      end
      r = $urandom_range(99);
      if (r < 65) begin
        send_rtp(pick_len(), cur_proto, RTP_VERSION, kind_in_range(), pick_udp_len(), FILL_RANDOM);
      end else if (r < 75) begin
        // well-formed apart from one filter field
        case ($urandom_range(2))
          0: send_rtp(pick_len(), cur_proto ^ 8'($urandom_range(255, 1)), RTP_VERSION,
                      kind_in_range(), pick_udp_len(), FILL_RANDOM);
          1: begin
            ver = 2'($urandom_range(2));
            if (ver == RTP_VERSION) ver = 2'd3;
            send_rtp(pick_len(), cur_proto, ver, kind_in_range(), pick_udp_len(), FILL_RANDOM);
          end
          default: begin
            if (cur_min > 0) kind = 7'($urandom_range(cur_min - 1, 0));
            else if (cur_max < 127) kind = 7'($urandom_range(127, cur_max + 1));
            else kind = 7'($urandom);
            send_rtp(pick_len(), cur_proto, RTP_VERSION, kind, pick_udp_len(), FILL_RANDOM);
          end
        endcase
      end else if (r < 85) begin
        send_rtp(int'($urandom_range(39, 1)), cur_proto, RTP_VERSION, kind_in_range(),
                 pick_udp_len(), FILL_RANDOM);
      end else begin
        send_rtp(int'($urandom_range(80, 1)), 8'($urandom), 2'($urandom), 7'($urandom),
                 16'($urandom), FILL_RANDOM);
      end
      pk++;
    end

    settle_block();
    $display("covered %0d packets, %0d bytes, %0d register settings", packets_sent,
             bytes_sent, settings_used);
    $display("%0d records compared, incl. a long receiver hold with the byte input stalled",
             records_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("rtp_header_extractor_tb: done, clean");
    end else begin
      $display("rtp_header_extractor_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rtpx_pkg.sv
rtl/rtpx_if.sv
rtl/rtpx_front.sv
rtl/rtpx_fifo.sv
rtl/rtpx_back.sv
rtl/rtp_header_extractor.sv
rtl/rtpx_checker.sv
dv/rtp_header_extractor_checker.sv
dv/rtp_header_extractor_tb.sv
